### hdl/cpbd_pkg.sv
`timescale 1ns / 1ps

package cpbd_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int IDX_W      = $clog2(FIFO_DEPTH);
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] PREV_RESET  = 8'hAA;
	localparam logic [7:0] PAIR_MASK   = 8'hFF;
	localparam logic [1:0] CHANGES_MAX = 2'd2;

	localparam logic [1:0] OP_FEED  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY = 2'd2;
	localparam logic [1:0] ST_DROPPED   = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] raw_byte;
		logic       end_of_chunk;
	} req_t;

	typedef struct packed {
		logic [7:0]        pop_data;
		logic [1:0]        status;
		logic              decoded_pushed;
		logic [FILL_W-1:0] fill_level;
		logic              is_empty;
		logic              is_full;
	} rsp_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       flush;
		logic [7:0] wdata;
	} fifo_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] count;
		logic              empty;
		logic              full;
	} fifo_stat_t;

endpackage

### hdl/complement_pair_byte_decoder_fifo.sv
`timescale 1ns / 1ps

// Complement-pair byte decoder with a decoded-byte FIFO.
// Request channel (req_valid / req_stall / req): each request carries an
// opcode: feed a raw sampled byte, pop one decoded byte, or flush the FIFO.
// A data byte arrives as the byte followed by its inverse; once two changes
// have been seen, the earlier byte of the pair is pushed into the FIFO.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
// request, in order, with popped data, status, push flag and FIFO level.
// The accepted request is registered into stage 1 and then into the
// response register. Throughput is one request per cycle while the
// receiver does not stall: decoder, FIFO pointers and the FIFO memory write or
// read are all settled in the accept cycle, the registered memory read feeds
// stage 1, and the response register follows.
// When the receiver stalls, the response register holds; one more request
// is still taken into stage 1, after which req_stall rises until the
// response drains.
// Reset empties the FIFO, sets the last byte to 0xAA and clears the change
// count and the drop flag. Flush empties the FIFO only.

module complement_pair_byte_decoder_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cpbd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cpbd_pkg::rsp_t rsp
);

	logic                        acc;
	logic                        adv_s1;
	logic                        valid_s1;
	logic                        pop_s1;
	cpbd_pkg::rsp_t              rsp_s1;
	cpbd_pkg::rsp_t              rsp_d;
	cpbd_pkg::rsp_t              rsp_q;
	logic                        rsp_valid_q;

	logic [7:0]                  prev_q;
	logic [1:0]                  chg_q;
	logic                        drop_q;
	logic [7:0]                  prev_d;
	logic [1:0]                  chg_d;
	logic                        drop_d;

	logic                        differs;
	logic [1:0]                  chg_inc;
	logic                        pair_done;
	logic [1:0]                  status_d;
	logic                        pushed_d;

	cpbd_pkg::fifo_cmd_t         fifo_cmd;
	cpbd_pkg::fifo_stat_t        fifo_stat;
	logic [cpbd_pkg::FILL_W-1:0] fill_next;
	logic [7:0]                  rd_data;

	assign acc       = req_valid && !req_stall;
	assign adv_s1    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv_s1;

	assign differs   = (req.raw_byte != prev_q);
	assign chg_inc   = (chg_q < cpbd_pkg::CHANGES_MAX) ? chg_q + 2'd1 : chg_q;
	assign pair_done = differs && ((req.raw_byte ^ prev_q) == cpbd_pkg::PAIR_MASK)
		&& (chg_inc > 2'd1);

	always_comb begin
		prev_d         = prev_q;
		chg_d          = chg_q;
		drop_d         = drop_q;
		status_d       = cpbd_pkg::ST_OK;
		pushed_d       = 1'b0;
		fifo_cmd.push  = 1'b0;
		fifo_cmd.pop   = 1'b0;
		fifo_cmd.flush = 1'b0;
		fifo_cmd.wdata = prev_q;
		if (acc) begin
			case (req.opcode)
				cpbd_pkg::OP_FEED: begin
					if (drop_q) begin
						status_d = cpbd_pkg::ST_DROPPED;
						if (req.end_of_chunk) begin
							drop_d = 1'b0;
						end
					end else if (differs) begin
						chg_d = pair_done ? 2'd0 : chg_inc;
						if (pair_done && fifo_stat.full) begin
							// previous byte is kept, rest of chunk is dropped
							status_d = cpbd_pkg::ST_OVERFLOW;
							drop_d   = !req.end_of_chunk;
						end else begin
							prev_d        = req.raw_byte;
							fifo_cmd.push = pair_done;
							pushed_d      = pair_done;
						end
					end
				end
				cpbd_pkg::OP_POP: begin
					if (fifo_stat.empty) begin
						status_d = cpbd_pkg::ST_POP_EMPTY;
					end else begin
						fifo_cmd.pop = 1'b1;
					end
				end
				cpbd_pkg::OP_FLUSH: begin
					fifo_cmd.flush = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	cpbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (fifo_cmd),
		.stat      (fifo_stat),
		.fill_next (fill_next),
		.rd_data   (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= cpbd_pkg::PREV_RESET;
			chg_q       <= '0;
			drop_q      <= 1'b0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			prev_q <= prev_d;
			chg_q  <= chg_d;
			drop_q <= drop_d;
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_comb begin
		rsp_d          = rsp_s1;
		// popped byte comes from the registered memory read
		rsp_d.pop_data = pop_s1 ? rd_data : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pop_s1                <= fifo_cmd.pop;
			rsp_s1.pop_data       <= '0;
			rsp_s1.status         <= status_d;
			rsp_s1.decoded_pushed <= pushed_d;
			rsp_s1.fill_level     <= fill_next;
			rsp_s1.is_empty       <= (fill_next == '0);
			rsp_s1.is_full        <= (fill_next == cpbd_pkg::FILL_W'(cpbd_pkg::FIFO_DEPTH));
		end
		if (adv_s1 && valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.count <= cpbd_pkg::FILL_W'(cpbd_pkg::FIFO_DEPTH))
		else $error("fifo count above depth");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.opcode == cpbd_pkg::OP_FLUSH |=> fifo_stat.empty)
		else $error("fifo not empty after flush");

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q && !(acc && req.opcode == cpbd_pkg::OP_FEED && req.end_of_chunk)
		|=> drop_q)
		else $error("drop flag cleared before end of chunk");

	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.decoded_pushed |-> rsp.status == cpbd_pkg::ST_OK
		&& !rsp.is_empty)
		else $error("push reported with bad status or empty fifo");

endmodule

### hdl/cpbd_fifo.sv
`timescale 1ns / 1ps

module cpbd_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpbd_pkg::fifo_cmd_t           cmd,
	output cpbd_pkg::fifo_stat_t          stat,
	output logic [cpbd_pkg::FILL_W-1:0]   fill_next,
	output logic [7:0]                    rd_data
);

	logic [7:0]                  mem [cpbd_pkg::FIFO_DEPTH];
	logic [cpbd_pkg::IDX_W-1:0]  wr_ptr_q;
	logic [cpbd_pkg::IDX_W-1:0]  rd_ptr_q;
	logic [cpbd_pkg::FILL_W-1:0] count_q;

	// callers only push when not full and pop when not empty
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_ptr_q] <= cmd.wdata;
		end
		if (cmd.pop) begin
			rd_data <= mem[rd_ptr_q];
		end
	end

	always_comb begin
		fill_next = count_q;
		if (cmd.flush) begin
			fill_next = '0;
		end else if (cmd.push) begin
			fill_next = count_q + cpbd_pkg::FILL_W'(1);
		end else if (cmd.pop) begin
			fill_next = count_q - cpbd_pkg::FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			count_q <= fill_next;
			if (cmd.flush) begin
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
			end else begin
				if (cmd.push) begin
					wr_ptr_q <= wr_ptr_q + cpbd_pkg::IDX_W'(1);
				end
				if (cmd.pop) begin
					rd_ptr_q <= rd_ptr_q + cpbd_pkg::IDX_W'(1);
				end
			end
		end
	end

	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == cpbd_pkg::FILL_W'(cpbd_pkg::FIFO_DEPTH));

endmodule
